// ===== sv/lnd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnd_pkg: shared types and constants of the linked node deque
// Node store size, field widths, request kinds, status codes, sequencer state.
// ---------------------------------------------------------------------------
package lnd_pkg;

    localparam int NODES  = 16;
    localparam int DATA_W = 32;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);

    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LINK,
        S_FIX,
        S_OUT
    } state_t;

endpackage

// ===== sv/linked_node_deque.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linked_node_deque: double-ended queue on a circular doubly linked node store
// Push/pop at either end; every request returns popped value, status, peeks
// and count. Nodes live in three RAMs (value, next, prev) with a free list.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | kind, data_in
//  out     | out_valid / out_ready| data_out, status, front_value,
//          |                      | back_value, is_empty, count
//
//  A good request passes through accept, read link, write link, fix link and
//  result; a refused one (pop on empty, push on full) goes from accept straight
//  to result. The limit is the dependent read of a link followed by two writes
//  on the one write port of the next and prev RAMs.
//  A new request is taken once the previous result has been delivered.
//  Reset sets the free list chain by per-entry valid bits on the next RAM,
//  so no clearing pass is run; the block is ready right after reset.
//  A stalled result holds in the output registers until out_ready.
// ---------------------------------------------------------------------------
module linked_node_deque
    import lnd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic signed [DATA_W-1:0] data_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] data_out,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] back_value,
    output logic                     is_empty,
    output logic [CNT_W-1:0]         count
);

    state_t              state_reg, state_next;
    kind_t               kind_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   dout_reg;
    status_t             status_reg;
    logic [DATA_W-1:0]   front_reg, back_reg;
    logic [NODE_W-1:0]   head_reg, tail_reg, free_reg, link_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [NODES-1:0]    nvld_reg;
    logic                nrd_vld_reg;
    logic [NODE_W-1:0]   nrd_addr_reg;

    logic                accept;
    kind_t               kind_in;
    status_t             status_in;
    logic                is_push;
    logic                many;
    logic [NODE_W-1:0]   next_eff;
    logic [NODE_W-1:0]   link_now;

    logic                val_we, nxt_we, prv_we;
    logic [NODE_W-1:0]   val_waddr, nxt_waddr, prv_waddr;
    logic [NODE_W-1:0]   val_raddr, nxt_raddr, prv_raddr;
    logic [DATA_W-1:0]   val_wdata, val_rdata;
    logic [NODE_W-1:0]   nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;

    lnd_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    lnd_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    lnd_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (prv_raddr),
        .rdata (prv_rdata)
    );

    assign kind_in = kind_t'(kind);
    assign accept  = in_valid && in_ready;
    assign is_push = !kind_reg[1];
    assign many    = (count_reg > CNT_W'(1));

    // unwritten next entries still hold the reset free chain
    assign next_eff = nrd_vld_reg ? nxt_rdata
                    : (nrd_addr_reg == NODE_W'(NODES - 1)) ? '0
                    : nrd_addr_reg + 1'b1;
    assign link_now = (kind_reg == KIND_POP_BACK) ? prv_rdata : next_eff;

    always_comb
    begin
        if (!kind_in[1])
        begin
            status_in = (count_reg == CNT_W'(NODES)) ? ST_FULL : ST_DONE;
        end
        else
        begin
            status_in = (count_reg == '0) ? ST_EMPTY : ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        val_we     = 1'b0;
        val_waddr  = free_reg;
        val_wdata  = data_reg;
        val_raddr  = link_now;
        nxt_we     = 1'b0;
        nxt_waddr  = free_reg;
        nxt_wdata  = head_reg;
        nxt_raddr  = is_push ? free_reg : head_reg;
        prv_we     = 1'b0;
        prv_waddr  = free_reg;
        prv_wdata  = tail_reg;
        prv_raddr  = tail_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = (status_in == ST_DONE) ? S_READ : S_OUT;
                end
            end
            S_READ:
            begin
                state_next = S_LINK;
            end
            S_LINK:
            begin
                state_next = S_FIX;
                if (is_push)
                begin
                    // new node takes its value and both links at once
                    val_we    = 1'b1;
                    nxt_we    = 1'b1;
                    prv_we    = 1'b1;
                    nxt_wdata = (count_reg == '0) ? free_reg : head_reg;
                    prv_wdata = (count_reg == '0) ? free_reg : tail_reg;
                end
                else
                begin
                    // return the victim to the free list and link its neighbour past it
                    nxt_we    = 1'b1;
                    nxt_waddr = (kind_reg == KIND_POP_FRONT) ? head_reg : tail_reg;
                    nxt_wdata = free_reg;
                    prv_we    = many;
                    if (kind_reg == KIND_POP_FRONT)
                    begin
                        prv_waddr = link_now;
                        prv_wdata = tail_reg;
                    end
                    else
                    begin
                        prv_waddr = head_reg;
                        prv_wdata = link_now;
                    end
                end
            end
            S_FIX:
            begin
                state_next = S_OUT;
                if (is_push)
                begin
                    nxt_we    = (count_reg != '0);
                    nxt_waddr = tail_reg;
                    nxt_wdata = free_reg;
                    prv_we    = (count_reg != '0);
                    prv_waddr = head_reg;
                    prv_wdata = free_reg;
                end
                else
                begin
                    nxt_we = many;
                    if (kind_reg == KIND_POP_FRONT)
                    begin
                        nxt_waddr = tail_reg;
                        nxt_wdata = link_reg;
                    end
                    else
                    begin
                        nxt_waddr = link_reg;
                        nxt_wdata = head_reg;
                    end
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
            count_reg  <= '0;
            front_reg  <= '0;
            back_reg   <= '0;
            nvld_reg   <= '0;
            status_reg <= ST_DONE;
            dout_reg   <= '0;
        end
        else
        begin
            if (nxt_we)
            begin
                nvld_reg[nxt_waddr] <= 1'b1;
            end
            if (accept)
            begin
                status_reg <= status_in;
                dout_reg   <= (kind_in[1] && status_in == ST_DONE)
                            ? ((kind_in == KIND_POP_FRONT) ? front_reg : back_reg)
                            : '0;
            end
            if (state_reg == S_FIX)
            begin
                if (is_push)
                begin
                    free_reg  <= link_reg;
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == '0)
                    begin
                        head_reg  <= free_reg;
                        tail_reg  <= free_reg;
                        front_reg <= data_reg;
                        back_reg  <= data_reg;
                    end
                    else if (kind_reg == KIND_PUSH_FRONT)
                    begin
                        head_reg  <= free_reg;
                        front_reg <= data_reg;
                    end
                    else
                    begin
                        tail_reg <= free_reg;
                        back_reg <= data_reg;
                    end
                end
                else
                begin
                    free_reg  <= (kind_reg == KIND_POP_FRONT) ? head_reg : tail_reg;
                    count_reg <= count_reg - 1'b1;
                    if (!many)
                    begin
                        head_reg  <= '0;
                        tail_reg  <= '0;
                        front_reg <= '0;
                        back_reg  <= '0;
                    end
                    else if (kind_reg == KIND_POP_FRONT)
                    begin
                        head_reg  <= link_reg;
                        front_reg <= val_rdata;
                    end
                    else
                    begin
                        tail_reg <= link_reg;
                        back_reg <= val_rdata;
                    end
                end
            end
        end
    end

    // payload and read tracking registers
    always_ff @(posedge clk)
    begin
        nrd_vld_reg  <= nvld_reg[nxt_raddr];
        nrd_addr_reg <= nxt_raddr;
        if (accept)
        begin
            kind_reg <= kind_in;
            data_reg <= data_in;
        end
        if (state_reg == S_LINK)
        begin
            link_reg <= link_now;
        end
    end

    assign data_out    = dout_reg;
    assign status      = status_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign count       = count_reg;
    assign is_empty    = (count_reg == '0);

endmodule

// ===== sv/lnd_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnd_ram: generic single write port, single read port RAM
// Read data is registered: it shows the entry in the cycle after the address.
// ---------------------------------------------------------------------------
module lnd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== sv/lnd_check.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnd_check: port-level checks of the linked node deque
// Watches the request and result channels and the reported queue state.
// ---------------------------------------------------------------------------
module lnd_check
    import lnd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] data_out,
    input logic [1:0]               status,
    input logic signed [DATA_W-1:0] front_value,
    input logic signed [DATA_W-1:0] back_value,
    input logic                     is_empty,
    input logic [CNT_W-1:0]         count
);

    // one request in flight: in_ready falls right after a request is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one is in flight");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == '0)) && (count <= CNT_W'(NODES)))
        else $error("empty flag or count out of step");

    a_empty_peek: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> front_value == '0 && back_value == '0)
        else $error("peek of an empty queue is not zero");

    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_FULL) |-> data_out == '0)
        else $error("refused request returned a value");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> is_empty)
        else $error("pop refused on a non-empty queue");

endmodule

bind linked_node_deque lnd_check u_lnd_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_out    (data_out),
    .status      (status),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .count       (count)
);
